// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL of the matrix multiply block, used by imm_ctrl.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/imm_pkg.sv -----
// Shared types, codes and helpers for the integer matrix multiply block.
// Used by every module under rtl except imm_store; depends on nothing else.
`timescale 1ns / 1ps

package imm_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 8;

    localparam int ACTION_W = 2;
    localparam int IDX_W    = 3;
    localparam int VALUE_W  = 8;
    localparam int SUM_W    = 19;
    localparam int DIM_W    = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [ACTION_W-1:0] ACT_WRITE_A = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE_B = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_COMPUTE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS     = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // Per-cycle control for the multiply-accumulate unit.
    typedef struct packed {
        logic issue;   // a pair of operands is being read this cycle
        logic first;   // first term of the dot product
        logic lastk;   // final term of the dot product
    } mac_ctl_t;

    // A size of zero acts as one; anything above the limit acts as the limit.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] lim);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = 4'd1;
        else if (v > lim)
            r = lim;
        else
            r = v;
        return r;
    endfunction

endpackage

// ----- rtl/imm_store.sv -----
// Element store for one matrix: one write port and one read port with
// registered read data. Stand-alone; no package dependency.
`timescale 1ns / 1ps

module imm_store #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/imm_mac.sv -----
// Shared multiply-accumulate unit: a registered multiplier feeding one
// accumulator, with a flag that holds a finished dot product. Uses imm_pkg.
`timescale 1ns / 1ps

module imm_mac #(
    parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  imm_pkg::mac_ctl_t        ctl,
    input  logic [ELEM_BITS-1:0]     a_data,
    input  logic [ELEM_BITS-1:0]     b_data,
    input  logic                     take,
    output logic                     res_ready,
    output logic [imm_pkg::SUM_W-1:0] res_sum
);

    localparam int PROD_W = 2 * ELEM_BITS;
    // At most eight terms are summed, so three guard bits are enough.
    localparam int ACC_W  = PROD_W + 3;

    imm_pkg::mac_ctl_t s1_reg;
    imm_pkg::mac_ctl_t s2_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic              ready_reg;
    logic              ready_next;

    // s1 lines up with the read data of the stores, s2 with the product.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg    <= '0;
            s2_reg    <= '0;
            ready_reg <= 1'b0;
        end
        else
        begin
            s1_reg    <= ctl;
            s2_reg    <= s1_reg;
            ready_reg <= ready_next;
        end
    end

    always_comb
    begin
        if (s2_reg.first)
            acc_next = ACC_W'(prod_reg);
        else
            acc_next = acc_reg + ACC_W'(prod_reg);
    end

    always_comb
    begin
        ready_next = ready_reg;
        if (s2_reg.issue && s2_reg.lastk)
            ready_next = 1'b1;
        else if (take)
            ready_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_reg.issue)
        begin
            prod_reg <= a_data * b_data;
        end
        if (s2_reg.issue)
        begin
            acc_reg <= acc_next;
        end
    end

    assign res_ready = ready_reg;
    assign res_sum   = imm_pkg::SUM_W'(acc_reg);

endmodule

// ----- rtl/imm_ctrl.sv -----
// Sequencer of the matrix multiply block: size registers, input handshake,
// the row/column/term counters and the output register. Uses imm_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module imm_ctrl #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [imm_pkg::ACTION_W-1:0]  action,
    input  logic                          cfg_wen,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [imm_pkg::DIM_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [imm_pkg::IDX_W-1:0]     out_row,
    output logic [imm_pkg::IDX_W-1:0]     out_col,
    output logic [imm_pkg::SUM_W-1:0]     sum,
    output logic                          last,
    output logic [imm_pkg::IDX_W-1:0]     rd_i,
    output logic [imm_pkg::IDX_W-1:0]     rd_j,
    output logic [imm_pkg::IDX_W-1:0]     rd_k,
    output imm_pkg::mac_ctl_t             mac_ctl,
    input  logic                          res_ready,
    input  logic [imm_pkg::SUM_W-1:0]     res_sum,
    output logic                          take
);

    localparam int DIM_LIMIT = (MAX_DIM < 8) ? MAX_DIM : 8;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    logic [imm_pkg::DIM_W-1:0] a_rows_reg;
    logic [imm_pkg::DIM_W-1:0] inner_reg;
    logic [imm_pkg::DIM_W-1:0] b_cols_reg;

    logic [imm_pkg::IDX_W-1:0] i_reg, i_next;
    logic [imm_pkg::IDX_W-1:0] j_reg, j_next;
    logic [imm_pkg::IDX_W-1:0] k_reg, k_next;

    logic [imm_pkg::IDX_W-1:0] n_last;
    logic [imm_pkg::IDX_W-1:0] m_last;
    logic [imm_pkg::IDX_W-1:0] l_last;

    logic                      out_valid_reg, out_valid_next;
    logic [imm_pkg::IDX_W-1:0] out_row_reg;
    logic [imm_pkg::IDX_W-1:0] out_col_reg;
    logic [imm_pkg::SUM_W-1:0] out_sum_reg;
    logic                      out_last_reg;

    logic in_accept;
    logic out_free;
    logic load;
    logic entry_last;
    logic k_last;

    assign n_last = imm_pkg::IDX_W'(imm_pkg::clamp_dim(a_rows_reg,
                        imm_pkg::DIM_W'(DIM_LIMIT)) - 4'd1);
    assign m_last = imm_pkg::IDX_W'(imm_pkg::clamp_dim(inner_reg,
                        imm_pkg::DIM_W'(DIM_LIMIT)) - 4'd1);
    assign l_last = imm_pkg::IDX_W'(imm_pkg::clamp_dim(b_cols_reg,
                        imm_pkg::DIM_W'(DIM_LIMIT)) - 4'd1);

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && (state_reg == ST_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign load       = (state_reg == ST_WAIT) && res_ready && out_free;
    assign entry_last = (i_reg == n_last) && (j_reg == l_last);
    assign k_last     = (k_reg == m_last);

    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (action == imm_pkg::ACT_COMPUTE))
                begin
                    state_next = ST_ISSUE;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_ISSUE:
            begin
                if (k_last)
                begin
                    state_next = ST_WAIT;
                    k_next     = '0;
                end
                else
                begin
                    k_next = k_reg + 3'd1;
                end
            end
            ST_WAIT:
            begin
                // The entry leaves only once the output register can take it.
                if (load)
                begin
                    if (entry_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                        if (j_reg == l_last)
                        begin
                            j_next = '0;
                            i_next = i_reg + 3'd1;
                        end
                        else
                        begin
                            j_next = j_reg + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            a_rows_reg    <= imm_pkg::DIM_RESET;
            inner_reg     <= imm_pkg::DIM_RESET;
            b_cols_reg    <= imm_pkg::DIM_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
            begin
                case (cfg_addr)
                    imm_pkg::CFG_A_ROWS:     a_rows_reg <= cfg_data;
                    imm_pkg::CFG_INNER_SIZE: inner_reg  <= cfg_data;
                    imm_pkg::CFG_B_COLS:     b_cols_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_row_reg  <= i_reg;
            out_col_reg  <= j_reg;
            out_sum_reg  <= res_sum;
            out_last_reg <= entry_last;
        end
    end

    assign mac_ctl.issue = (state_reg == ST_ISSUE);
    assign mac_ctl.first = (k_reg == '0);
    assign mac_ctl.lastk = k_last;

    assign rd_i = i_reg;
    assign rd_j = j_reg;
    assign rd_k = k_reg;
    assign take = load;

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign sum       = out_sum_reg;
    assign last      = out_last_reg;

    `ASSERT_NEXT(a_issue_to_wait, (state_reg == ST_ISSUE) && k_last, state_reg == ST_WAIT, "issue of the final term did not lead to the wait state")
    `ASSERT_SAME(a_ready_in_wait, $rose(res_ready), state_reg == ST_WAIT, "dot product finished outside the wait state")
    `ASSERT_NEXT(a_last_beat_idle, load && entry_last, (state_reg == ST_IDLE) && out_valid && last, "final entry did not end the product")

endmodule

// ----- rtl/integer_matrix_multiply.sv -----
// Top level of the integer matrix multiply block: element stores, the
// shared multiply-accumulate unit and the sequencer. Uses imm_pkg.
`timescale 1ns / 1ps

// An element write (action 0 for A, 1 for B) is stored as it is taken and
// gives no beat. A compute item (action 2) emits a_rows * b_cols beats in
// row-major order, the final one marked by last; the input is stalled until
// the final beat has been loaded into the output register. The single
// multiplier and the one read port of each store read one term per cycle;
// the registered read, the registered product and the accumulator then lie
// between the final term and the load of the entry, and a stalled output
// holds the entry in the wait state. The user is to write sizes through the
// cfg port only while the block is idle; the block does not enforce this.
// 0 acts as 1 and values above min(store dimension, 8) act as that limit.
// Elements must be written before they are used by a compute.
module integer_matrix_multiply #(
    parameter int MAX_DIM   = imm_pkg::MAX_DIM_DEF,
    parameter int ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [imm_pkg::ACTION_W-1:0]  action,
    input  logic [imm_pkg::IDX_W-1:0]     row,
    input  logic [imm_pkg::IDX_W-1:0]     col,
    input  logic [imm_pkg::VALUE_W-1:0]   value,
    input  logic                          cfg_wen,
    input  logic [imm_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic [imm_pkg::DIM_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [imm_pkg::IDX_W-1:0]     out_row,
    output logic [imm_pkg::IDX_W-1:0]     out_col,
    output logic [imm_pkg::SUM_W-1:0]     sum,
    output logic                          last
);

    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    logic                      in_accept;
    logic                      wr_in_range;
    logic                      a_we;
    logic                      b_we;
    logic [ADDR_W-1:0]         waddr;
    logic [ELEM_BITS-1:0]      wdata;
    logic [ADDR_W-1:0]         a_raddr;
    logic [ADDR_W-1:0]         b_raddr;
    logic [ELEM_BITS-1:0]      a_rdata;
    logic [ELEM_BITS-1:0]      b_rdata;
    logic [imm_pkg::IDX_W-1:0] rd_i;
    logic [imm_pkg::IDX_W-1:0] rd_j;
    logic [imm_pkg::IDX_W-1:0] rd_k;
    imm_pkg::mac_ctl_t         mac_ctl;
    logic                      res_ready;
    logic [imm_pkg::SUM_W-1:0] res_sum;
    logic                      take;

    assign in_accept   = in_valid && !in_stall;
    // Writes outside the store dimension are dropped.
    assign wr_in_range = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign a_we  = in_accept && wr_in_range && (action == imm_pkg::ACT_WRITE_A);
    assign b_we  = in_accept && wr_in_range && (action == imm_pkg::ACT_WRITE_B);
    assign waddr = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
    assign wdata = ELEM_BITS'(value);

    assign a_raddr = ADDR_W'(rd_i) * ADDR_W'(MAX_DIM) + ADDR_W'(rd_k);
    assign b_raddr = ADDR_W'(rd_k) * ADDR_W'(MAX_DIM) + ADDR_W'(rd_j);

    imm_store #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (ELEM_BITS),
        .ADDR_W (ADDR_W)
    ) u_a_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    imm_store #(
        .DEPTH  (STORE_DEPTH),
        .DATA_W (ELEM_BITS),
        .ADDR_W (ADDR_W)
    ) u_b_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    imm_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .a_data    (a_rdata),
        .b_data    (b_rdata),
        .take      (take),
        .res_ready (res_ready),
        .res_sum   (res_sum)
    );

    imm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .sum       (sum),
        .last      (last),
        .rd_i      (rd_i),
        .rd_j      (rd_j),
        .rd_k      (rd_k),
        .mac_ctl   (mac_ctl),
        .res_ready (res_ready),
        .res_sum   (res_sum),
        .take      (take)
    );

endmodule
